// File: hw/rtl/assert_macros.svh
// assertion macros used by the projection core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication with the consequent checked in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/lrip_pkg.sv
// shared types and constants of the range image projection block
`default_nettype none
package lrip_pkg;

    localparam int unsigned CoordWidth = 20;
    localparam int unsigned RingWidth  = 8;
    localparam int unsigned RowWidth   = 7;
    localparam int unsigned ColWidth   = 12;
    localparam int unsigned PixWidth   = 19;
    localparam int unsigned RangeWidth = 20;
    localparam int unsigned CfgWidth   = 24;
    localparam int unsigned CfgIdxWidth = 3;

    // sum of coordinate squares fits 42 bits, root 21 bits
    localparam int unsigned SqWidth   = 42;
    localparam int unsigned RootWidth = 21;

    // cordic: vector scaled by 2^20, gain growth below 2x, plus sign
    localparam int unsigned CordWidth = 44;
    localparam int unsigned AccWidth  = 30;
    localparam int unsigned AngIters  = 20;
    localparam int unsigned AngWidth  = 19;

    localparam logic signed [AccWidth-1:0] HalfTurnQ8 = 30'sd46080000;
    // 2^37 / 1000 rounded up, exact floor divide by 1000 for quotients below 2^27
    localparam logic [27:0] MilliRecip = 28'd137438954;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_USE_RING   = 3'd0,
        CFG_ROWS_PER   = 3'd1,
        CFG_COLS_PER   = 3'd2,
        CFG_BOTTOM     = 3'd3,
        CFG_MIN_RANGE  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [CoordWidth-1:0] pos_x_mm;
        logic [CoordWidth-1:0] pos_y_mm;
        logic [CoordWidth-1:0] pos_z_mm;
        logic [RingWidth-1:0]  ring_number;
    } point_t;

    typedef struct packed {
        logic                  point_valid;
        logic [RowWidth-1:0]   row_index;
        logic [ColWidth-1:0]   column_index;
        logic [PixWidth-1:0]   pixel_index;
        logic [RangeWidth-1:0] range_mm;
    } proj_t;

    typedef struct packed {
        logic                  use_ring_channel;
        logic [23:0]           rows_per_degree_q16;
        logic [23:0]           cols_per_degree_q16;
        logic [16:0]           bottom_angle_mdeg;
        logic [19:0]           min_range_mm;
    } cfg_t;

    // arctangent of 2^-i in 1/256 millidegree
    function automatic logic signed [AccWidth-1:0] atan_q8(input logic [4:0] i);
        logic signed [AccWidth-1:0] r;
        unique case (i)
            5'd0: r = 30'sd11520000;
            5'd1: r = 30'sd6800653;
            5'd2: r = 30'sd3593278;
            5'd3: r = 30'sd1824004;
            5'd4: r = 30'sd915542;
            5'd5: r = 30'sd458217;
            5'd6: r = 30'sd229164;
            5'd7: r = 30'sd114589;
            5'd8: r = 30'sd57295;
            5'd9: r = 30'sd28648;
            5'd10: r = 30'sd14324;
            5'd11: r = 30'sd7162;
            5'd12: r = 30'sd3581;
            5'd13: r = 30'sd1790;
            5'd14: r = 30'sd895;
            5'd15: r = 30'sd448;
            5'd16: r = 30'sd224;
            5'd17: r = 30'sd112;
            5'd18: r = 30'sd56;
            5'd19: r = 30'sd28;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/lrip_stream_if.sv
// valid/ready channel carrying one payload word
`default_nettype none
interface lrip_stream_if #(
    parameter int unsigned Width = 8
);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/lrip_sqrt_pipe.sv
// pipelined rounded square root, up to two result bits per stage
`default_nettype none
module lrip_sqrt_pipe #(
    parameter int unsigned Lat = 11
) (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic [lrip_pkg::SqWidth-1:0]     radicand,
    output logic      [lrip_pkg::RootWidth-1:0]   root
);
    // each stage settles up to two root bits; rounding follows the last stage
    localparam int unsigned W = lrip_pkg::SqWidth;
    localparam int unsigned Bits = lrip_pkg::RootWidth;
    localparam int unsigned PerStage = (Bits + Lat - 1) / Lat;

    logic [W-1:0] rem_reg [0:Lat];
    logic [W-1:0] res_reg [0:Lat];

    always_comb
    begin
        rem_reg[0] = radicand;
        res_reg[0] = '0;
    end

    for (genvar s = 0; s < Lat; s++)
    begin : g_stage
        logic [W-1:0] rem_next;
        logic [W-1:0] res_next;
        always_comb
        begin
            logic [W-1:0] rem;
            logic [W-1:0] res;
            logic [W-1:0] bitv;
            rem = rem_reg[s];
            res = res_reg[s];
            for (int k = 0; k < PerStage; k++)
            begin
                if (s * PerStage + k < Bits)
                begin
                    bitv = W'(1) << (2 * (Bits - 1 - (s * PerStage + k)));
                    if (rem >= res + bitv)
                    begin
                        rem = rem - (res + bitv);
                        res = (res >> 1) + bitv;
                    end
                    else
                    begin
                        res = res >> 1;
                    end
                end
            end
            rem_next = rem;
            res_next = res;
        end
        logic [W-1:0] rem_q;
        logic [W-1:0] res_q;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_q <= rem_next;
                res_q <= res_next;
            end
        end
        always_comb
        begin
            rem_reg[s+1] = rem_q;
            res_reg[s+1] = res_q;
        end
    end

    assign root = (rem_reg[Lat] > res_reg[Lat]) ? Bits'(res_reg[Lat] + W'(1))
                                                : Bits'(res_reg[Lat]);
endmodule
`default_nettype wire

// File: hw/rtl/lrip_cordic_pipe.sv
// pipelined cordic atan2 in millidegrees, a fold stage then one rotation per stage
`default_nettype none
module lrip_cordic_pipe (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic signed [lrip_pkg::RootWidth:0] a,
    input  wire logic signed [lrip_pkg::RootWidth:0] b,
    output logic signed [lrip_pkg::AngWidth-1:0]     angle
);
    localparam int unsigned CW = lrip_pkg::CordWidth;
    localparam int unsigned AW = lrip_pkg::AccWidth;
    localparam int unsigned N  = lrip_pkg::AngIters;

    function automatic logic signed [lrip_pkg::AngWidth-1:0] AngWidthCast(
        input logic signed [AW-1:0] v);
        return v[lrip_pkg::AngWidth-1:0];
    endfunction

    logic signed [CW-1:0] vx_s [0:N];
    logic signed [CW-1:0] vy_s [0:N];
    logic signed [AW-1:0] acc_s [0:N];
    logic                 zero_s [0:N];
    logic                 neg_s [0:N];

    // set up the half-plane fold before the first rotation
    logic signed [CW-1:0] vx_reg, vy_reg;
    logic signed [AW-1:0] acc_reg;
    logic zero_reg, neg_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg <= (a == '0);
            neg_reg  <= b[lrip_pkg::RootWidth];
            if (b[lrip_pkg::RootWidth])
            begin
                vx_reg  <= (-CW'(b)) <<< 20;
                vy_reg  <= (-CW'(a)) <<< 20;
                acc_reg <= a[lrip_pkg::RootWidth] ? -lrip_pkg::HalfTurnQ8
                                                  : lrip_pkg::HalfTurnQ8;
            end
            else
            begin
                vx_reg  <= CW'(b) <<< 20;
                vy_reg  <= CW'(a) <<< 20;
                acc_reg <= '0;
            end
        end
    end
    always_comb
    begin
        vx_s[0] = vx_reg;
        vy_s[0] = vy_reg;
        acc_s[0] = acc_reg;
        zero_s[0] = zero_reg;
        neg_s[0] = neg_reg;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        logic signed [CW-1:0] dx, dy, vx_q, vy_q;
        logic signed [AW-1:0] acc_q;
        logic zero_q, neg_q;
        // shifts truncate toward zero
        assign dx = vy_s[i][CW-1] ? -((-vy_s[i]) >>> i) : (vy_s[i] >>> i);
        assign dy = vx_s[i][CW-1] ? -((-vx_s[i]) >>> i) : (vx_s[i] >>> i);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_q <= zero_s[i];
                neg_q  <= neg_s[i];
                if (!vy_s[i][CW-1])
                begin
                    vx_q  <= vx_s[i] + dx;
                    vy_q  <= vy_s[i] - dy;
                    acc_q <= acc_s[i] + lrip_pkg::atan_q8(5'(i));
                end
                else
                begin
                    vx_q  <= vx_s[i] - dx;
                    vy_q  <= vy_s[i] + dy;
                    acc_q <= acc_s[i] - lrip_pkg::atan_q8(5'(i));
                end
            end
        end
        always_comb
        begin
            vx_s[i+1] = vx_q;
            vy_s[i+1] = vy_q;
            acc_s[i+1] = acc_q;
            zero_s[i+1] = zero_q;
            neg_s[i+1] = neg_q;
        end
    end

    logic signed [AW-1:0] acc_f, mag;
    assign acc_f = acc_s[N];
    assign mag = acc_f[AW-1] ? -acc_f : acc_f;

    always_comb
    begin
        if (zero_s[N])
            angle = neg_s[N] ? 19'sd180000 : 19'sd0;
        else if (acc_f[AW-1])
            angle = -AngWidthCast((mag + AW'(128)) >>> 8);
        else
            angle = AngWidthCast((mag + AW'(128)) >>> 8);
    end
endmodule
`default_nettype wire

// File: hw/rtl/lidar_range_image_projection_core.sv
// Lidar point to range-image projection. One point is accepted per clock cycle
// while the skid register is empty, and one result word leaves per point. The
// pipeline depth is set by the elevation path (squares, an 11-stage root of
// x^2+y^2, the cordic fold and 20 rotations, then the row and column products and
// the scaling, whose constant divide is a shift and a reciprocal multiply). The
// whole datapath advances together under one enable, so a stalled output holds
// every stage; a one-word skid register at the output keeps the input ready
// registered. Configuration writes only while idle; the block does not enforce it.
`default_nettype none
`include "assert_macros.svh"
module lidar_range_image_projection_core #(
    parameter int unsigned IMAGE_ROWS = 16,
    parameter int unsigned IMAGE_COLS = 1800
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cfg_we,
    input  wire logic [lrip_pkg::CfgIdxWidth-1:0]        cfg_index,
    input  wire logic [lrip_pkg::CfgWidth-1:0]           cfg_data,
    lrip_stream_if.sink                                  point_in,
    lrip_stream_if.source                                proj_out
);
    localparam int unsigned SqLat = 11;
    localparam int unsigned CordLat = lrip_pkg::AngIters + 1;
    // stages: sq 1, root SqLat, cordic CordLat, mul 1, scale 1; checks feed out_reg
    localparam int unsigned Lat = 1 + SqLat + CordLat + 2;
    localparam int unsigned RW = lrip_pkg::RootWidth;

    lrip_pkg::cfg_t cfg_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.use_ring_channel    <= 1'b0;
            cfg_reg.rows_per_degree_q16 <= 24'd32768;
            cfg_reg.cols_per_degree_q16 <= 24'd327680;
            cfg_reg.bottom_angle_mdeg   <= 17'd15100;
            cfg_reg.min_range_mm        <= 20'd1000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lrip_pkg::CFG_USE_RING:  cfg_reg.use_ring_channel <= cfg_data[0];
                lrip_pkg::CFG_ROWS_PER:  cfg_reg.rows_per_degree_q16 <= cfg_data;
                lrip_pkg::CFG_COLS_PER:  cfg_reg.cols_per_degree_q16 <= cfg_data;
                lrip_pkg::CFG_BOTTOM:    cfg_reg.bottom_angle_mdeg <= cfg_data[16:0];
                lrip_pkg::CFG_MIN_RANGE: cfg_reg.min_range_mm <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // pipeline advance and skid
    logic en;
    logic [Lat-1:0] vld_reg;
    logic skid_vld_reg;
    lrip_pkg::proj_t skid_reg, res;
    assign en = !skid_vld_reg;
    assign point_in.ready = en;

    lrip_pkg::point_t pin;
    assign pin = point_in.data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[Lat-2:0], point_in.valid};
    end

    // stage 1: squares
    logic signed [19:0] px, py, pz;
    logic signed [39:0] xx, yy, zz;
    assign px = $signed(pin.pos_x_mm);
    assign py = $signed(pin.pos_y_mm);
    assign pz = $signed(pin.pos_z_mm);
    assign xx = 40'(px) * 40'(px);
    assign yy = 40'(py) * 40'(py);
    assign zz = 40'(pz) * 40'(pz);

    logic [lrip_pkg::SqWidth-1:0] hsq_reg, rsq_reg;
    logic signed [RW:0] x1_reg, y1_reg;
    logic signed [19:0] z1_reg;
    logic [7:0] ring1_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hsq_reg <= 42'(xx) + 42'(yy);
            rsq_reg <= 42'(xx) + 42'(yy) + 42'(zz);
            x1_reg <= 22'(px);
            y1_reg <= 22'(py);
            z1_reg <= pz;
            ring1_reg <= pin.ring_number;
        end
    end

    logic [RW-1:0] h_root, r_root;
    lrip_sqrt_pipe #(.Lat(SqLat)) u_hroot (.clk, .en, .radicand(hsq_reg), .root(h_root));
    lrip_sqrt_pipe #(.Lat(SqLat)) u_rroot (.clk, .en, .radicand(rsq_reg), .root(r_root));

    // delay lines alongside the root and the cordic
    logic signed [RW:0] xd_reg [0:SqLat-1];
    logic signed [RW:0] yd_reg [0:SqLat-1];
    logic signed [19:0] zd_reg [0:SqLat-1];
    logic [7:0] ringd_reg [0:SqLat+CordLat-1];
    logic [RW-1:0] rd_reg [0:CordLat-1];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xd_reg[0] <= x1_reg;
            yd_reg[0] <= y1_reg;
            zd_reg[0] <= z1_reg;
            ringd_reg[0] <= ring1_reg;
            for (int k = 1; k < SqLat; k++)
            begin
                xd_reg[k] <= xd_reg[k-1];
                yd_reg[k] <= yd_reg[k-1];
                zd_reg[k] <= zd_reg[k-1];
            end
            for (int k = 1; k < SqLat + CordLat; k++)
                ringd_reg[k] <= ringd_reg[k-1];
            rd_reg[0] <= r_root;
            for (int k = 1; k < CordLat; k++)
                rd_reg[k] <= rd_reg[k-1];
        end
    end

    // azimuth inputs pass through the xd_reg and yd_reg delay lines; it aligns with elevation
    logic signed [lrip_pkg::AngWidth-1:0] elev, azim;
    lrip_cordic_pipe u_elev (.clk, .en, .a(22'(zd_reg[SqLat-1])),
                             .b($signed({1'b0, h_root})), .angle(elev));
    lrip_cordic_pipe u_azim (.clk, .en, .a(xd_reg[SqLat-1]), .b(yd_reg[SqLat-1]),
                             .angle(azim));

    // stage: products
    logic signed [19:0] rsum, cdif;
    logic signed [24:0] rpd, cpd;
    assign rsum = 20'(elev) + $signed({3'b0, cfg_reg.bottom_angle_mdeg});
    assign cdif = 20'(azim) - 20'sd90000;
    assign rpd = $signed({1'b0, cfg_reg.rows_per_degree_q16});
    assign cpd = $signed({1'b0, cfg_reg.cols_per_degree_q16});

    logic signed [44:0] rowp_reg, colp_reg;
    logic [7:0] ring_m_reg;
    logic [RW-1:0] range_m_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rowp_reg <= 45'(rsum) * 45'(rpd);
            colp_reg <= 45'(cdif) * 45'(cpd);
            ring_m_reg <= ringd_reg[SqLat+CordLat-1];
            range_m_reg <= rd_reg[CordLat-1];
        end
    end

    // stage: divide by 65536000 as a shift by 16, then a reciprocal multiply for 1000
    logic signed [20:0] row_s_reg, rnd_s_reg;
    logic [7:0] ring_s_reg;
    logic [RW-1:0] range_s_reg;
    logic [44:0] rmag, cmag;
    logic [26:0] rq, cq;
    logic [54:0] rprod, cprod;
    assign rmag = rowp_reg[44] ? 45'(-rowp_reg) : 45'(rowp_reg);
    assign cmag = colp_reg[44] ? 45'(-colp_reg) : 45'(colp_reg);
    assign rq = 27'(rmag >> 16);
    assign cq = 27'((cmag + 45'd32768000) >> 16);
    assign rprod = 55'(rq) * 55'(lrip_pkg::MilliRecip);
    assign cprod = 55'(cq) * 55'(lrip_pkg::MilliRecip);
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_s_reg <= rowp_reg[44] ? -21'(rprod >> 37) : 21'(rprod >> 37);
            rnd_s_reg <= colp_reg[44] ? -21'(cprod >> 37) : 21'(cprod >> 37);
            ring_s_reg <= ring_m_reg;
            range_s_reg <= range_m_reg;
        end
    end

    // final checks: wrap, bounds, minimum range, pixel, into the output register
    logic signed [21:0] col_a, col_b, row_v;
    logic ok;
    always_comb
    begin
        col_a = 22'(IMAGE_COLS / 2) - 22'(rnd_s_reg);
        col_b = (col_a >= 22'(IMAGE_COLS)) ? col_a - 22'(IMAGE_COLS) : col_a;
        row_v = cfg_reg.use_ring_channel ? $signed({14'b0, ring_s_reg}) : 22'(row_s_reg);
        ok = !(row_v < 0) && (row_v < 22'(IMAGE_ROWS)) && !(col_b < 0)
           && (col_b < 22'(IMAGE_COLS))
           && !({1'b0, range_s_reg} < {2'b0, cfg_reg.min_range_mm});
        res.point_valid  = ok;
        res.row_index    = ok ? row_v[6:0] : '0;
        res.column_index = ok ? col_b[11:0] : '0;
        res.pixel_index  = ok ? 19'(32'(col_b[11:0]) + 32'(row_v[6:0]) * 32'(IMAGE_COLS))
                              : '0;
        res.range_mm     = range_s_reg[19:0];
    end

    logic out_vld_reg;
    lrip_pkg::proj_t out_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (!out_vld_reg || proj_out.ready)
            begin
                out_vld_reg  <= skid_vld_reg || vld_reg[Lat-1];
                skid_vld_reg <= 1'b0;
            end
            else if (en && vld_reg[Lat-1])
                skid_vld_reg <= 1'b1;
        end
    end
    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || proj_out.ready)
            out_reg <= skid_vld_reg ? skid_reg : res;
        else if (en)
            skid_reg <= res;
    end

    assign proj_out.valid = out_vld_reg;
    assign proj_out.data  = out_reg;

    `ASSERT_NEXT(a_skid_hold, clk, rst_n, skid_vld_reg && !proj_out.ready,
                 skid_vld_reg && out_vld_reg, "skid word dropped")
    `ASSERT_IMPL(a_skid_needs_out, clk, rst_n, skid_vld_reg, out_vld_reg,
                 "skid full with empty output")
    `ASSERT_IMPL(a_reject_zero, clk, rst_n, proj_out.valid && !out_reg.point_valid,
                 out_reg.pixel_index == '0, "rejected word with pixel")
endmodule
`default_nettype wire

// File: tb/tb_lidar_range_image_projection_core.sv
// testbench for the lidar range image projection core: scoreboard and drivers
`timescale 1ns / 1ps
module tb_lidar_range_image_projection_core;

    localparam int Rows = 16;
    localparam int Cols = 1800;
    localparam int Latency = 35;

    // expected projection store and checker
    class proj_scoreboard;
        lrip_pkg::proj_t pending[$];
        int errors;

        function void note_point(lrip_pkg::proj_t p);
            pending = {pending, p};
        endfunction

        function void check_proj(lrip_pkg::proj_t got);
            lrip_pkg::proj_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected word %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.point_valid !== want.point_valid)
            begin
                $error("point_valid exp %0d got %0d", want.point_valid, got.point_valid);
                errors++;
            end
            if (got.row_index !== want.row_index)
            begin
                $error("row_index exp %0d got %0d", want.row_index, got.row_index);
                errors++;
            end
            if (got.column_index !== want.column_index)
            begin
                $error("column_index exp %0d got %0d", want.column_index,
                    got.column_index);
                errors++;
            end
            if (got.pixel_index !== want.pixel_index)
            begin
                $error("pixel_index exp %0d got %0d", want.pixel_index, got.pixel_index);
                errors++;
            end
            if (got.range_mm !== want.range_mm)
            begin
                $error("range_mm exp %0d got %0d", want.range_mm, got.range_mm);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    lrip_pkg::cfg_idx_t cfg_index;
    logic [lrip_pkg::CfgWidth-1:0] cfg_data;

    lrip_stream_if #(.Width($bits(lrip_pkg::point_t))) point_in ();
    lrip_stream_if #(.Width($bits(lrip_pkg::proj_t))) proj_out ();

    lidar_range_image_projection_core #(.IMAGE_ROWS(Rows), .IMAGE_COLS(Cols)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .point_in(point_in.sink),
        .proj_out(proj_out.source)
    );

    proj_scoreboard board;
    lrip_pkg::cfg_t cfg;
    int hold_cycles;
    longint atan_steps[lrip_pkg::AngIters] = '{
        11520000, 6800653, 3593278, 1824004, 915542, 458217, 229164, 114589,
        57295, 28648, 14324, 7162, 3581, 1790, 895, 448, 224, 112, 56, 28
    };

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint shift_tz(longint v, int k);
        if (v >= 0)
            return v >>> k;
        return -((-v) >>> k);
    endfunction

    function automatic longint root_round(longint v);
        longint rem, res, b;
        rem = v;
        res = 0;
        b = 64'sd1 <<< 62;
        while (b > rem)
            b = b >>> 2;
        while (b != 0)
        begin
            if (rem >= res + b)
            begin
                rem = rem - (res + b);
                res = (res >>> 1) + b;
            end
            else
                res = res >>> 1;
            b = b >>> 2;
        end
        if (rem > res)
            res++;
        return res;
    endfunction

    // cordic vectoring, millidegrees
    function automatic longint angle_mdeg(longint a, longint b);
        longint vx, vy, acc, dx, dy;
        vx = b;
        vy = a;
        acc = 0;
        if (a == 0)
            return (b < 0) ? 180000 : 0;
        if (vx < 0)
        begin
            vx = -vx;
            vy = -vy;
            acc = (a > 0) ? 46080000 : -46080000;
        end
        vx = vx * 1048576;
        vy = vy * 1048576;
        for (int i = 0; i < lrip_pkg::AngIters; i++)
        begin
            dx = shift_tz(vy, i);
            dy = shift_tz(vx, i);
            if (vy >= 0)
            begin
                vx += dx;
                vy -= dy;
                acc += atan_steps[i];
            end
            else
            begin
                vx -= dx;
                vy += dy;
                acc -= atan_steps[i];
            end
        end
        if (acc >= 0)
            return (acc + 128) >>> 8;
        return -((-acc + 128) >>> 8);
    endfunction

    function automatic lrip_pkg::proj_t project_point(lrip_pkg::point_t p);
        lrip_pkg::proj_t r;
        longint x, y, z, hsq, rng, row, col, azim, v, mag, rnd;
        bit ok;
        x = longint'($signed(p.pos_x_mm));
        y = longint'($signed(p.pos_y_mm));
        z = longint'($signed(p.pos_z_mm));
        hsq = x * x + y * y;
        rng = root_round(hsq + z * z);
        ok = 1'b1;
        if (cfg.use_ring_channel)
            row = p.ring_number;
        else
            row = ((angle_mdeg(z, root_round(hsq)) + longint'(cfg.bottom_angle_mdeg))
                * longint'(cfg.rows_per_degree_q16)) / 65536000;
        if (row < 0 || row >= Rows)
            ok = 1'b0;
        azim = angle_mdeg(x, y);
        v = (azim - 90000) * longint'(cfg.cols_per_degree_q16);
        mag = (v >= 0) ? v : -v;
        rnd = (mag + 32768000) / 65536000;
        if (v < 0)
            rnd = -rnd;
        col = Cols / 2 - rnd;
        if (col >= Cols)
            col -= Cols;
        if (col < 0 || col >= Cols)
            ok = 1'b0;
        if (rng < longint'(cfg.min_range_mm))
            ok = 1'b0;
        r = '0;
        if (ok)
        begin
            r.point_valid = 1'b1;
            r.row_index = row[lrip_pkg::RowWidth-1:0];
            r.column_index = col[lrip_pkg::ColWidth-1:0];
            r.pixel_index = lrip_pkg::PixWidth'(col + row * Cols);
        end
        r.range_mm = rng[lrip_pkg::RangeWidth-1:0];
        return r;
    endfunction

    // the caller drops cfg_we after the last write of a series
    task automatic write_reg(lrip_pkg::cfg_idx_t idx, logic [lrip_pkg::CfgWidth-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            lrip_pkg::CFG_USE_RING: cfg.use_ring_channel = val[0];
            lrip_pkg::CFG_ROWS_PER: cfg.rows_per_degree_q16 = val[23:0];
            lrip_pkg::CFG_COLS_PER: cfg.cols_per_degree_q16 = val[23:0];
            lrip_pkg::CFG_BOTTOM: cfg.bottom_angle_mdeg = val[16:0];
            lrip_pkg::CFG_MIN_RANGE: cfg.min_range_mm = val[19:0];
            default: ;
        endcase
    endtask

    task automatic send_point(lrip_pkg::point_t p, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 17) : 0;
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            point_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_in.valid <= 1'b1;
        point_in.data <= p;
        @(posedge clk);
        while (!point_in.ready)
            @(posedge clk);
        board.note_point(project_point(p));
    endtask

    task automatic wait_idle();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (Latency + 5) @(posedge clk);
    endtask

    function automatic logic [19:0] rand_coord(int mode);
        case (mode)
            0: return 20'($urandom_range(0, 40000) - 20000);
            1: return 20'($urandom_range(0, 4000) - 2000);
            2: return 20'($urandom_range(0, 10) - 5);
            default: return 20'($urandom);
        endcase
    endfunction

    function automatic lrip_pkg::point_t rand_point();
        lrip_pkg::point_t p;
        int m;
        m = $urandom_range(0, 3);
        p.pos_x_mm = rand_coord(m);
        p.pos_y_mm = rand_coord(m);
        p.pos_z_mm = (m == 3) ? rand_coord(3) : 20'($signed(p.pos_x_mm) / 8
            + $signed(20'($urandom_range(0, 2000) - 1000)));
        p.ring_number = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 17));
        return p;
    endfunction

    // result side: random stall, one long hold-off when requested
    initial
    begin
        int gap;
        proj_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles != 0)
            begin
                proj_out.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
            if (gap != 0)
            begin
                proj_out.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            proj_out.ready <= 1'b1;
            @(posedge clk);
            while (!proj_out.valid)
                @(posedge clk);
            board.check_proj(lrip_pkg::proj_t'(proj_out.data));
        end
    end

    initial
    begin
        lrip_pkg::point_t p;
        logic [19:0] ext[4];
        ext = '{20'h7FFFF, 20'h80000, 20'h00000, 20'hFFFFF};
        board = new();
        hold_cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = lrip_pkg::CFG_USE_RING;
        cfg_data = '0;
        point_in.valid = 1'b0;
        point_in.data = '0;
        cfg = '{1'b0, 24'd32768, 24'd327680, 17'd15100, 20'd1000};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, zero vector, both angle half planes
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
            begin
                p = '{ext[i], ext[j], ext[(i + j) % 4], 8'(i * 85)};
                send_point(p, 1'b0);
            end
        send_point('{20'd0, 20'd0, 20'd0, 8'd0}, 1'b0);
        send_point('{20'd0, -20'sd5000, 20'd0, 8'd15}, 1'b0);
        send_point('{20'd5000, 20'd0, -20'sd2000, 8'd16}, 1'b0);
        send_point('{-20'sd5000, 20'd0, 20'd100, 8'd255}, 1'b0);
        send_point('{20'd1, 20'd999, 20'd0, 8'd1}, 1'b0);
        send_point('{20'd3000, 20'd3000, -20'sd40, 8'd7}, 1'b0);
        point_in.valid <= 1'b0;
        wait_idle();

        // long hold-off while the first words go in back to back, so the pipeline
        // fills and stalls the input
        hold_cycles = 120;
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph != 0)
            begin
                point_in.valid <= 1'b0;
                wait_idle();
                case (ph)
                    1:
                    begin
                        write_reg(lrip_pkg::CFG_USE_RING, 24'd1);
                        write_reg(lrip_pkg::CFG_MIN_RANGE, 24'd0);
                    end
                    2:
                    begin
                        write_reg(lrip_pkg::CFG_USE_RING, 24'd0);
                        write_reg(lrip_pkg::CFG_ROWS_PER, 24'hFFFFFF);
                        write_reg(lrip_pkg::CFG_COLS_PER, 24'hFFFFFF);
                        write_reg(lrip_pkg::CFG_BOTTOM, 24'd90000);
                        write_reg(lrip_pkg::CFG_MIN_RANGE, 24'hFFFFF);
                    end
                    3:
                    begin
                        write_reg(lrip_pkg::CFG_ROWS_PER, 24'd0);
                        write_reg(lrip_pkg::CFG_COLS_PER, 24'd0);
                        write_reg(lrip_pkg::CFG_BOTTOM, 24'd0);
                        write_reg(lrip_pkg::CFG_MIN_RANGE, 24'd1);
                    end
                    4:
                    begin
                        write_reg(lrip_pkg::CFG_ROWS_PER, 24'd1);
                        write_reg(lrip_pkg::CFG_COLS_PER, 24'd1);
                        write_reg(lrip_pkg::CFG_BOTTOM, 24'd45000);
                    end
                    default:
                    begin
                        write_reg(lrip_pkg::CFG_ROWS_PER, 24'($urandom_range(10000, 200000)));
                        write_reg(lrip_pkg::CFG_COLS_PER, 24'($urandom_range(100000, 700000)));
                        write_reg(lrip_pkg::CFG_BOTTOM, 24'($urandom_range(0, 30000)));
                        write_reg(lrip_pkg::CFG_MIN_RANGE, 24'($urandom_range(0, 3000)));
                    end
                endcase
                cfg_we <= 1'b0;
            end
            for (int n = 0; n < 190; n++)
            begin
                p = rand_point();
                send_point(p, (ph != 0 || n >= 60) && $urandom_range(0, 4) != 0);
            end
        end
        point_in.valid <= 1'b0;
        wait_idle();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/lrip_pkg.sv
hw/rtl/lrip_stream_if.sv
hw/rtl/lrip_sqrt_pipe.sv
hw/rtl/lrip_cordic_pipe.sv
hw/rtl/lidar_range_image_projection_core.sv
tb/tb_lidar_range_image_projection_core.sv
